[rtl/med3_pkg.sv]
// shared types and constants for the 3x3 median filter
package med3_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned WIN_N       = 9;
  localparam int unsigned FW_W        = 11;
  localparam int unsigned FH_W        = 12;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd512;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd512;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic [PIX_W-1:0]           pix_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;
  typedef logic [QCNT_W-1:0]          qcount_t;

  typedef struct packed {
    win_t win;
    logic last;
  } win_entry_t;

endpackage

[rtl/med3_ram.sv]
// generic simple dual-port ram with registered read
module med3_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/med3_front.sv]
// front end: geometry registers, raster counters, line stores and window
module med3_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [med3_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  med3_pkg::pix_t                 in_pixel_in,
  input  med3_pkg::qcount_t              q_count,
  output logic                           q_push,
  output med3_pkg::win_entry_t           q_entry
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW0 = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW  = (WW0 > med3_pkg::FW_W) ? WW0 : med3_pkg::FW_W;
  localparam int unsigned HW  = med3_pkg::FH_W;

  logic [med3_pkg::FW_W-1:0] fw_r;
  logic [HW-1:0]             fh_r;
  logic [CW-1:0]             col_r, col_nxt;
  logic [HW-1:0]             row_r, row_nxt;

  logic                      s1_valid_r;
  logic                      s1_emit_r;
  logic                      s1_last_r;
  logic [CW-1:0]             s1_col_r;
  med3_pkg::pix_t            s1_pix_r;
  med3_pkg::win_t            win_r, win_nxt;

  logic [WW-1:0]             fw_x, w_eff, c_x;
  logic [HW-1:0]             h_eff;
  logic                      accept, c_wrap, r_wrap, emit, last;
  logic [2*med3_pkg::PIX_W-1:0] ram_rdata, ram_wdata;
  med3_pkg::pix_t            top, mid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= med3_pkg::FRAME_WIDTH_RST;
      fh_r <= med3_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (med3_pkg::cfg_idx_t'(cfg_index))
        med3_pkg::CFG_FRAME_WIDTH:  fw_r <= cfg_data[med3_pkg::FW_W-1:0];
        med3_pkg::CFG_FRAME_HEIGHT: fh_r <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  always_comb begin
    fw_x = WW'(fw_r);
    if (fw_x < WW'(3)) begin
      w_eff = WW'(3);
    end else if (fw_x > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = fw_x;
    end
    h_eff = (fh_r < HW'(3)) ? HW'(3) : fh_r;
  end

  assign in_stall = ({1'b0, q_count} + {{med3_pkg::QCNT_W{1'b0}}, q_push})
                    >= (med3_pkg::QCNT_W + 1)'(med3_pkg::QUEUE_DEPTH);
  assign accept = in_valid && !in_stall;

  always_comb begin
    c_x    = WW'(col_r);
    c_wrap = (c_x + WW'(1)) >= w_eff;
    r_wrap = ({1'b0, row_r} + (HW + 1)'(1)) >= {1'b0, h_eff};
    emit   = (c_x < w_eff) && (row_r < h_eff) && (row_r >= HW'(2)) && (c_x >= WW'(2));
    last   = (row_r == h_eff - HW'(1)) && (c_x == w_eff - WW'(1));
    col_nxt = col_r;
    row_nxt = row_r;
    if (c_wrap) begin
      col_nxt = '0;
      row_nxt = r_wrap ? '0 : row_r + HW'(1);
    end else begin
      col_nxt = CW'(c_x + WW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit_r <= emit;
      s1_last_r <= last;
      s1_col_r  <= col_r;
      s1_pix_r  <= in_pixel_in;
    end
  end

  // word holds {row r-1, row r-2} for one column
  med3_ram #(
    .WIDTH (2 * med3_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign mid       = ram_rdata[2*med3_pkg::PIX_W-1:med3_pkg::PIX_W];
  assign top       = ram_rdata[med3_pkg::PIX_W-1:0];
  assign ram_wdata = {s1_pix_r, mid};

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      win_nxt[k] = win_r[k+3];
    end
    win_nxt[6] = top;
    win_nxt[7] = mid;
    win_nxt[8] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  assign q_push        = s1_valid_r && s1_emit_r;
  assign q_entry.win   = win_nxt;
  assign q_entry.last  = s1_last_r;

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < WW'(MAX_WIDTH))
    else $error("column counter beyond line store");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r) |-> s1_emit_r)
    else $error("frame end flagged on a border pixel");

endmodule

[rtl/med3_queue.sv]
// short window queue between front end and median pipeline
module med3_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  med3_pkg::win_entry_t push_entry,
  input  logic                 pop,
  output logic                 q_valid,
  output med3_pkg::win_entry_t q_entry,
  output med3_pkg::qcount_t    count
);

  localparam int unsigned D  = med3_pkg::QUEUE_DEPTH;
  localparam int unsigned PW = med3_pkg::QPTR_W;

  med3_pkg::win_entry_t mem_r [D];
  logic [PW-1:0]        wptr_r, rptr_r;
  med3_pkg::qcount_t    count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(D - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(D - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + med3_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - med3_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

  assign q_valid = (count_r != '0);
  assign q_entry = mem_r[rptr_r];
  assign count   = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != med3_pkg::QCNT_W'(D)) || pop)
    else $error("transfer into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

[rtl/med3_back.sv]
// back end: three stage median-of-nine compare network with output register
module med3_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  med3_pkg::win_entry_t q_entry,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output med3_pkg::pix_t       out_median_out,
  output logic                 out_frame_last
);

  function automatic med3_pkg::win_t cx(med3_pkg::win_t v, int unsigned i, int unsigned j);
    med3_pkg::win_t t;
    t = v;
    if (v[i] > v[j]) begin
      t[i] = v[j];
      t[j] = v[i];
    end
    return t;
  endfunction

  function automatic med3_pkg::win_t net_a(med3_pkg::win_t v);
    med3_pkg::win_t p;
    p = v;
    p = cx(p, 1, 2); p = cx(p, 4, 5); p = cx(p, 7, 8);
    p = cx(p, 0, 1); p = cx(p, 3, 4); p = cx(p, 6, 7);
    p = cx(p, 1, 2); p = cx(p, 4, 5); p = cx(p, 7, 8);
    return p;
  endfunction

  function automatic med3_pkg::win_t net_b(med3_pkg::win_t v);
    med3_pkg::win_t p;
    p = v;
    p = cx(p, 0, 3); p = cx(p, 5, 8); p = cx(p, 4, 7);
    p = cx(p, 3, 6); p = cx(p, 1, 4); p = cx(p, 2, 5);
    return p;
  endfunction

  function automatic med3_pkg::pix_t net_c(med3_pkg::win_t v);
    med3_pkg::win_t p;
    p = v;
    p = cx(p, 4, 7); p = cx(p, 4, 2); p = cx(p, 6, 4); p = cx(p, 4, 2);
    return p[4];
  endfunction

  logic           adv;
  logic           va_r, vb_r, vo_r;
  logic           la_r, lb_r, lo_r;
  med3_pkg::win_t sa_r, sb_r;
  med3_pkg::pix_t med_r;

  assign adv   = !(vo_r && out_stall);
  assign q_pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      va_r <= q_valid;
      vb_r <= va_r;
      vo_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_r  <= net_a(q_entry.win);
      la_r  <= q_entry.last;
      sb_r  <= net_b(sa_r);
      lb_r  <= la_r;
      med_r <= net_c(sb_r);
      lo_r  <= lb_r;
    end
  end

  assign out_valid      = vo_r;
  assign out_median_out = med_r;
  assign out_frame_last = lo_r;

  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && !adv) |=> (vb_r && $stable(sb_r) && $stable(lb_r)))
    else $error("network stage changed while output stalled");

  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> va_r)
    else $error("popped window lost in first stage");

endmodule

[rtl/median_filter_3x3_top.sv]
// top level of the streaming 3x3 median filter
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_stall    in_pixel_in[7:0]
//   out      out  out_valid/out_stall  out_median_out[7:0], out_frame_last
//   cfg      in   cfg_we               cfg_index, cfg_data[11:0]
//
// one pixel per clock sustained while in_stall stays low
// the line store ram is read once and written once per pixel, which sets that rate
// in_stall rises only when the 4-entry window queue would fill, counting a push in flight
// synchronous reset clears counters, window and pipeline; line stores are not cleared
// a stall on the output holds the median pipeline while the front keeps filling the queue
module median_filter_3x3_top #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [med3_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_pixel_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_median_out,
  output logic                           out_frame_last
);

  logic                 push, pop, q_valid;
  med3_pkg::win_entry_t push_entry, q_entry;
  med3_pkg::qcount_t    q_count;

  med3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pixel_in (in_pixel_in),
    .q_count     (q_count),
    .q_push      (push),
    .q_entry     (push_entry)
  );

  med3_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .count      (q_count)
  );

  med3_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_median_out (out_median_out),
    .out_frame_last (out_frame_last)
  );

endmodule
